### hdl/hysteresis_relay_controller_defines.svh
// ----------------------------------------------------------------------------
// Hysteresis relay controller assertion macros
// Clocked assertion wrappers shared by the controller and datapath modules.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_RELAY_CONTROLLER_DEFINES_SVH
`define HYSTERESIS_RELAY_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset
`define HRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define HRC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define HRC_ASSERT(label, prop, msg)
`define HRC_NEVER(label, expr, msg)

`endif

`endif

### hdl/hrc_pkg.sv
// ----------------------------------------------------------------------------
// Hysteresis relay controller package
// Field widths, limits, register indexes and reset values, modes, event codes
// and the control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hrc_pkg;

  // Default sensor count
  localparam int NUM_SENSORS_DEF = 6;

  // Field widths
  localparam int TEMP_W   = 13;
  localparam int AVG_W    = 12;
  localparam int HYST_W   = 11;
  localparam int SEC_W    = 16;
  localparam int MODE_W   = 2;
  localparam int MIN_W    = 11;
  localparam int NOW_W    = 32;
  localparam int CODE_W   = 3;
  localparam int SIDX_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFGIDX_W = 3;
  localparam int MSEC_W   = SEC_W + 10;

  // Limits and constants
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -13'sd880;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 13'sd2000;
  localparam logic signed [TEMP_W-1:0] BOOT_TEMP = 13'sd464;
  localparam logic signed [AVG_W-1:0]  BOOT_AVG  = 12'sd464;
  localparam logic [MIN_W:0]           MIN_PER_DAY = 12'd1440;
  localparam logic [MSEC_W-1:0]        MS_PER_S    = MSEC_W'(1000);

  // Register indexes
  localparam logic [CFGIDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFGIDX_W-1:0] REG_HYSTERESIS = 3'd1;
  localparam logic [CFGIDX_W-1:0] REG_MAX_ON     = 3'd2;
  localparam logic [CFGIDX_W-1:0] REG_COOLDOWN   = 3'd3;
  localparam logic [CFGIDX_W-1:0] REG_MODE       = 3'd4;
  localparam logic [CFGIDX_W-1:0] REG_SCHED_EN   = 3'd5;
  localparam logic [CFGIDX_W-1:0] REG_SCHED_START = 3'd6;
  localparam logic [CFGIDX_W-1:0] REG_SCHED_LEN  = 3'd7;

  // Register reset values
  localparam logic [AVG_W-1:0]  RST_THRESHOLD   = 12'd480;
  localparam logic [HYST_W-1:0] RST_HYSTERESIS  = 11'd16;
  localparam logic [SEC_W-1:0]  RST_MAX_ON      = 16'd120;
  localparam logic [SEC_W-1:0]  RST_COOLDOWN    = 16'd60;
  localparam logic [MIN_W-1:0]  RST_SCHED_START = 11'd720;
  localparam logic [MIN_W-1:0]  RST_SCHED_LEN   = 11'd10;

  // Modes
  localparam logic [MODE_W-1:0] MODE_AUTO      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL_ON = 2'd2;

  // Event codes
  localparam logic [CODE_W-1:0] EV_NONE        = 3'd0;
  localparam logic [CODE_W-1:0] EV_AUTO_ON     = 3'd1;
  localparam logic [CODE_W-1:0] EV_AUTO_OFF    = 3'd2;
  localparam logic [CODE_W-1:0] EV_PROTECT_OFF = 3'd3;
  localparam logic [CODE_W-1:0] EV_SCHED_ON    = 3'd4;
  localparam logic [CODE_W-1:0] EV_SCHED_OFF   = 3'd5;
  localparam logic [CODE_W-1:0] EV_MANUAL_ON   = 3'd6;
  localparam logic [CODE_W-1:0] EV_MANUAL_OFF  = 3'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic sample_write;
    logic capture;
    logic acc_step;
    logic div_start;
    logic avg_load;
    logic load_first;
    logic load_second;
  } hrc_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic sum_last;
    logic cnt_zero;
    logic div_done;
    logic out_free;
    logic two_events;
  } hrc_sts_t;

endpackage

### hdl/hysteresis_relay_controller.sv
// ----------------------------------------------------------------------------
// Hysteresis relay controller
// On/off thermostat with hysteresis, protection timer and daily schedule.
// ----------------------------------------------------------------------------
// A sample transaction (cmd 0) stores or rejects one sensor reading. A control
// transaction (cmd 1) sums the fresh sensors, reading one sensor a cycle,
// divides the sum in a divider that makes one quotient bit a cycle, and then
// decides and loads its first result; when no sensor is fresh the divider is
// skipped. A second result for the same step is loaded at the edge at which
// the first one is taken. Input stays stalled while a control step is in
// progress, and a stalled output holds the step until its results are loaded.
// Results sit in an output register, so a new transaction is taken while the
// last result of the previous step still waits.
// Configuration is written through cfg_write, cfg_index and cfg_data. The user
// must see that configuration is written only while no control step is in
// progress; the block itself does not enforce this.
module hysteresis_relay_controller
  import hrc_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFGIDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [SIDX_W-1:0]        sensor_index,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic                     sensor_present,
  input  logic [NOW_W-1:0]         now_ms,
  input  logic [MIN_W-1:0]         minute_of_day,
  input  logic                     clock_valid,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     relay_on,
  output logic [CODE_W-1:0]        event_code,
  output logic signed [AVG_W-1:0]  average,
  output logic                     schedule_active,
  output logic                     last
);

  hrc_ctl_t ctl;
  hrc_sts_t sts;

  // Sequencer
  hrc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .item_cmd(cmd),
    .in_stall(in_stall),
    .sts     (sts),
    .ctl     (ctl)
  );

  // Datapath
  hrc_dp #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sensor_index   (sensor_index),
    .temperature    (temperature),
    .sensor_present (sensor_present),
    .now_ms         (now_ms),
    .minute_of_day  (minute_of_day),
    .clock_valid    (clock_valid),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .relay_on       (relay_on),
    .event_code     (event_code),
    .average        (average),
    .schedule_active(schedule_active),
    .last           (last),
    .ctl            (ctl),
    .sts            (sts)
  );

endmodule

### hdl/hrc_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrc_div #(
  parameter int NW = 16,
  parameter int DW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[NW-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
  end

  // Track the iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= CW'(cnt + 1'b1);
      if (cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

### hdl/hrc_ctrl.sv
// ----------------------------------------------------------------------------
// Hysteresis relay controller sequencer
// Steps a control transaction through sum, divide, decide and result hand-off.
// ----------------------------------------------------------------------------
module hrc_ctrl
  import hrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     item_cmd,
  output logic     in_stall,
  input  hrc_sts_t sts,
  output hrc_ctl_t ctl
);

`include "hysteresis_relay_controller_defines.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_EMIT2  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (item_cmd) begin
            ctl.capture = 1'b1;
            state_next  = S_SUM;
          end else begin
            ctl.sample_write = 1'b1;
          end
        end
      end
      S_SUM: begin
        ctl.acc_step = 1'b1;
        if (sts.sum_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.cnt_zero) begin
          state_next = S_DECIDE;
        end else begin
          ctl.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          ctl.avg_load = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          ctl.load_first = 1'b1;
          state_next     = sts.two_events ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        if (sts.out_free) begin
          ctl.load_second = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `HRC_ASSERT(a_sample_stays_idle, (in_valid && !in_stall && !item_cmd) |=> (state == S_IDLE), "sample transaction left idle")
  `HRC_ASSERT(a_div_to_decide, (state == S_DIV && sts.div_done) |=> (state == S_DECIDE), "divide did not hand off to decide")
  `HRC_ASSERT(a_emit2_origin, (state == S_EMIT2) |-> ($past(state) == S_DECIDE || $past(state) == S_EMIT2), "second result without a decision")

endmodule

### hdl/hrc_dp.sv
// ----------------------------------------------------------------------------
// Hysteresis relay controller datapath
// Configuration, sensor store, averaging, relay decision and output register.
// ----------------------------------------------------------------------------
module hrc_dp
  import hrc_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFGIDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [SIDX_W-1:0]        sensor_index,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic                     sensor_present,
  input  logic [NOW_W-1:0]         now_ms,
  input  logic [MIN_W-1:0]         minute_of_day,
  input  logic                     clock_valid,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic                     relay_on,
  output logic [CODE_W-1:0]        event_code,
  output logic signed [AVG_W-1:0]  average,
  output logic                     schedule_active,
  output logic                     last,
  input  hrc_ctl_t                 ctl,
  output hrc_sts_t                 sts
);

`include "hysteresis_relay_controller_defines.svh"

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CNT_W = $clog2(NUM_SENSORS + 1);
  localparam int SUM_W = TEMP_W + CNT_W;

  // Configuration registers
  logic signed [AVG_W-1:0] threshold;
  logic [HYST_W-1:0]       hysteresis;
  logic [SEC_W-1:0]        max_on_seconds;
  logic [SEC_W-1:0]        cooldown_seconds;
  logic [MODE_W-1:0]       mode;
  logic                    schedule_enable;
  logic [MIN_W-1:0]        schedule_start;
  logic [MIN_W-1:0]        schedule_len;
  logic [MSEC_W-1:0]       max_on_ms;
  logic [MSEC_W-1:0]       cooldown_ms;

  // Sensor store
  logic signed [TEMP_W-1:0] sensor_value [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]   sensor_fresh;
  logic [IDX_W-1:0]         widx;
  logic                     idx_ok;
  logic                     temp_ok;

  // Accumulation and division
  logic [IDX_W-1:0]        acc_idx;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        cnt;
  logic [SUM_W-1:0]        mag;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic [AVG_W-1:0]        quo_lo;

  // Control state
  logic signed [AVG_W-1:0] kept_avg;
  logic                    relay_state;
  logic                    spray_timing;
  logic [NOW_W-1:0]        spray_start;
  logic [NOW_W-1:0]        spray_end;
  logic                    has_sprayed;
  logic                    sched_was_active;
  logic [NOW_W-1:0]        cap_now;
  logic [MIN_W-1:0]        cap_minute;
  logic                    cap_clock_ok;

  // Pending second result
  logic              pend_relay;
  logic [CODE_W-1:0] pend_code;
  logic              pend_sched;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= RST_THRESHOLD;
      hysteresis       <= RST_HYSTERESIS;
      max_on_seconds   <= RST_MAX_ON;
      cooldown_seconds <= RST_COOLDOWN;
      mode             <= MODE_AUTO;
      schedule_enable  <= 1'b0;
      schedule_start   <= RST_SCHED_START;
      schedule_len     <= RST_SCHED_LEN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold        <= cfg_data[AVG_W-1:0];
        REG_HYSTERESIS:  hysteresis       <= cfg_data[HYST_W-1:0];
        REG_MAX_ON:      max_on_seconds   <= cfg_data[SEC_W-1:0];
        REG_COOLDOWN:    cooldown_seconds <= cfg_data[SEC_W-1:0];
        REG_MODE:        mode             <= cfg_data[MODE_W-1:0];
        REG_SCHED_EN:    schedule_enable  <= cfg_data[0];
        REG_SCHED_START: schedule_start   <= cfg_data[MIN_W-1:0];
        REG_SCHED_LEN:   schedule_len     <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Convert second limits to milliseconds
  always_ff @(posedge clk) begin
    max_on_ms   <= MSEC_W'(max_on_seconds) * MS_PER_S;
    cooldown_ms <= MSEC_W'(cooldown_seconds) * MS_PER_S;
  end

  // Check the incoming sample
  always_comb begin
    widx    = IDX_W'(sensor_index);
    idx_ok  = (32'(sensor_index) < 32'(NUM_SENSORS));
    temp_ok = sensor_present && (temperature >= TEMP_LOW) && (temperature <= TEMP_HIGH);
  end

  // Store a sample or mark the sensor stale
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        sensor_value[i] <= BOOT_TEMP;
      end
      sensor_fresh <= '1;
    end else if (ctl.sample_write && idx_ok) begin
      sensor_fresh[widx] <= temp_ok;
      if (temp_ok) sensor_value[widx] <= temperature;
    end
  end

  // Sum fresh sensors one per cycle
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      acc_idx      <= '0;
      sum          <= '0;
      cnt          <= '0;
      cap_now      <= now_ms;
      cap_minute   <= minute_of_day;
      cap_clock_ok <= clock_valid;
    end else if (ctl.acc_step) begin
      acc_idx <= IDX_W'(acc_idx + 1'b1);
      if (sensor_fresh[acc_idx]) begin
        sum <= sum + SUM_W'(sensor_value[acc_idx]);
        cnt <= CNT_W'(cnt + 1'b1);
      end
    end
  end

  // Divide the magnitude and restore the sign
  always_comb begin
    mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    quo_lo = div_quo[AVG_W-1:0];
  end

  hrc_div #(
    .NW(SUM_W),
    .DW(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(ctl.div_start),
    .num  (mag),
    .den  (cnt),
    .done (div_done),
    .quo  (div_quo)
  );

  // Schedule window test
  logic [MIN_W:0] win_end;
  logic [MIN_W:0] wrap1;
  logic [MIN_W:0] wrap2;
  logic [MIN_W:0] cur;
  logic [MIN_W:0] start_x;
  logic           sch;

  always_comb begin
    start_x = {1'b0, schedule_start};
    cur     = {1'b0, cap_minute};
    win_end = start_x + {1'b0, schedule_len};
    wrap1   = win_end - MIN_PER_DAY;
    wrap2   = (wrap1 >= MIN_PER_DAY) ? (wrap1 - MIN_PER_DAY) : wrap1;
    if (!schedule_enable || !cap_clock_ok || schedule_len == '0) begin
      sch = 1'b0;
    end else if (win_end <= MIN_PER_DAY) begin
      sch = (cur >= start_x) && (cur < win_end);
    end else begin
      sch = (cur >= start_x) || (cur < wrap2);
    end
  end

  // Relay decision chain: auto hysteresis, protection, schedule, manual
  logic signed [AVG_W+1:0] avg_x;
  logic signed [AVG_W+1:0] thr_x;
  logic signed [AVG_W+1:0] thr_lo;
  logic                    auto_m;
  logic                    want_on;
  logic                    cool_ok;
  logic                    on_a, off_a, off_b, on_c, off_c, on_m, off_m;
  logic                    r1, r2, r3, r_fin;
  logic                    ts1, ts2, ts3, ts_fin;
  logic [NOW_W-1:0]        st1, st3, st_fin;
  logic [NOW_W-1:0]        en1, en2, en3, en_fin;
  logic                    hs1, hs2, hs3, hs_fin;
  logic [3:0]              fired;
  logic [CODE_W-1:0]       code_a, code_c, code_m;
  logic [CODE_W-1:0]       first_code, last_code;
  logic                    first_relay;

  always_comb begin
    avg_x   = {{2{kept_avg[AVG_W-1]}}, kept_avg};
    thr_x   = {{2{threshold[AVG_W-1]}}, threshold};
    thr_lo  = thr_x - $signed({3'b000, hysteresis});
    auto_m  = (mode == MODE_AUTO);
    want_on = (mode == MODE_MANUAL_ON);
    cool_ok = !has_sprayed || ((cap_now - spray_end) >= NOW_W'(cooldown_ms));

    // Hysteresis step
    on_a  = auto_m && !relay_state && (avg_x >= thr_x) && cool_ok;
    off_a = auto_m && relay_state && (avg_x <= thr_lo);
    r1    = on_a ? 1'b1 : (off_a ? 1'b0 : relay_state);
    ts1   = on_a ? 1'b1 : (off_a ? 1'b0 : spray_timing);
    st1   = on_a ? cap_now : spray_start;
    en1   = off_a ? cap_now : spray_end;
    hs1   = has_sprayed || off_a;

    // Maximum on time protection
    off_b = auto_m && r1 && ts1 && ((cap_now - st1) >= NOW_W'(max_on_ms));
    r2    = off_b ? 1'b0 : r1;
    ts2   = off_b ? 1'b0 : ts1;
    en2   = off_b ? cap_now : en1;
    hs2   = hs1 || off_b;

    // Schedule window
    on_c  = auto_m && sch && !r2;
    off_c = auto_m && !sch && sched_was_active && r2 && (avg_x < thr_x);
    r3    = on_c ? 1'b1 : (off_c ? 1'b0 : r2);
    ts3   = on_c ? 1'b1 : (off_c ? 1'b0 : ts2);
    st3   = on_c ? cap_now : st1;
    en3   = off_c ? cap_now : en2;
    hs3   = hs2 || off_c;

    // Manual modes
    on_m   = !auto_m && want_on && !relay_state;
    off_m  = !auto_m && !want_on && relay_state;
    r_fin  = on_m ? 1'b1 : (off_m ? 1'b0 : r3);
    ts_fin = on_m ? 1'b1 : (off_m ? 1'b0 : ts3);
    st_fin = on_m ? cap_now : st3;
    en_fin = off_m ? cap_now : en3;
    hs_fin = hs3 || off_m;

    // Pick first and final events
    fired  = {on_m || off_m, on_c || off_c, off_b, on_a || off_a};
    code_a = on_a ? EV_AUTO_ON : EV_AUTO_OFF;
    code_c = on_c ? EV_SCHED_ON : EV_SCHED_OFF;
    code_m = on_m ? EV_MANUAL_ON : EV_MANUAL_OFF;

    if (fired[0]) begin
      first_code  = code_a;
      first_relay = on_a;
    end else if (fired[1]) begin
      first_code  = EV_PROTECT_OFF;
      first_relay = 1'b0;
    end else if (fired[2]) begin
      first_code  = code_c;
      first_relay = on_c;
    end else if (fired[3]) begin
      first_code  = code_m;
      first_relay = on_m;
    end else begin
      first_code  = EV_NONE;
      first_relay = r_fin;
    end

    if (fired[3]) begin
      last_code = code_m;
    end else if (fired[2]) begin
      last_code = code_c;
    end else if (fired[1]) begin
      last_code = EV_PROTECT_OFF;
    end else if (fired[0]) begin
      last_code = code_a;
    end else begin
      last_code = EV_NONE;
    end
  end

  // Update kept average and relay state
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_avg         <= BOOT_AVG;
      relay_state      <= 1'b0;
      spray_timing     <= 1'b0;
      spray_start      <= '0;
      spray_end        <= '0;
      has_sprayed      <= 1'b0;
      sched_was_active <= 1'b0;
    end else begin
      if (ctl.avg_load) begin
        kept_avg <= sum[SUM_W-1] ? (~quo_lo + AVG_W'(1)) : quo_lo;
      end
      if (ctl.load_first) begin
        relay_state  <= r_fin;
        spray_timing <= ts_fin;
        spray_start  <= st_fin;
        spray_end    <= en_fin;
        has_sprayed  <= hs_fin;
        if (auto_m) sched_was_active <= sch;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_first || ctl.load_second) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload and hold the second one
  always_ff @(posedge clk) begin
    if (ctl.load_first) begin
      relay_on        <= first_relay;
      event_code      <= first_code;
      average         <= kept_avg;
      schedule_active <= sch;
      last            <= ($countones(fired) < 2);
      pend_relay      <= r_fin;
      pend_code       <= last_code;
      pend_sched      <= sch;
    end else if (ctl.load_second) begin
      relay_on        <= pend_relay;
      event_code      <= pend_code;
      average         <= kept_avg;
      schedule_active <= pend_sched;
      last            <= 1'b1;
    end
  end

  // Status back to the sequencer
  always_comb begin
    sts.sum_last   = (acc_idx == IDX_W'(NUM_SENSORS - 1));
    sts.cnt_zero   = (cnt == '0);
    sts.div_done   = div_done;
    sts.out_free   = !out_valid || !out_stall;
    sts.two_events = ($countones(fired) >= 2);
  end

  `HRC_NEVER(a_timing_tracks_relay, spray_timing != relay_state, "spray timing out of step with relay")
  `HRC_ASSERT(a_div_nonzero, ctl.div_start |-> (cnt != '0), "divide started with no fresh sensor")
  `HRC_ASSERT(a_load_sets_valid, (ctl.load_first || ctl.load_second) |=> out_valid, "loaded result not presented")

endmodule

### test/hysteresis_relay_controller_checker.sv
// ----------------------------------------------------------------------------
// Hysteresis relay controller checker
// Watches the configuration port and both channels of the relay controller.
// Tracks the thermostat state, predicts the relay events of every control
// transaction and compares them, field by field, with the results in order.
// ----------------------------------------------------------------------------
module hysteresis_relay_controller_checker
  import hrc_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFGIDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     cmd,
  input  logic [SIDX_W-1:0]        sensor_index,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic                     sensor_present,
  input  logic [NOW_W-1:0]         now_ms,
  input  logic [MIN_W-1:0]         minute_of_day,
  input  logic                     clock_valid,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     relay_on,
  input  logic [CODE_W-1:0]        event_code,
  input  logic signed [AVG_W-1:0]  average,
  input  logic                     schedule_active,
  input  logic                     last,
  output int                       mismatches,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOW_READING  = -880;
  localparam int HIGH_READING = 2000;
  localparam int BOOT_READING = 464;
  localparam int DAY_MINUTES  = 1440;
  localparam int REPORT_LIMIT = 10;
  localparam logic [NOW_W-1:0] MS_PER_SECOND = 1000;
  localparam logic CONTROL = 1'b1;

  typedef struct packed {
    logic              relay;
    logic [CODE_W-1:0] code;
    logic [AVG_W-1:0]  avg;
    logic              sched;
    logic              last;
  } relay_result_t;

  relay_result_t    relay_events_due [$];
  logic [CFG_W-1:0] cfg_regs [8];
  int               reading [NUM_SENSORS];
  bit               reading_fresh [NUM_SENSORS];
  int               held_average;
  bit               relay;
  bit               spray_running;
  bit               has_sprayed;
  bit               window_was_open;
  logic [NOW_W-1:0] spray_start;
  logic [NOW_W-1:0] spray_end;
  int               fail_count;

  // Relay changes of the current control step: first and final only
  logic [CODE_W-1:0] step_code [2];
  bit                step_relay [2];
  int                step_changes;

  function automatic logic [CFG_W-1:0] reg_mask(input logic [CFGIDX_W-1:0] idx);
    case (idx) inside
      REG_THRESHOLD:              return 16'h0FFF;
      REG_MAX_ON, REG_COOLDOWN:   return 16'hFFFF;
      REG_MODE:                   return 16'h0003;
      REG_SCHED_EN:               return 16'h0001;
      default:                    return 16'h07FF;
    endcase
  endfunction

  // Switch the relay and record the change for this step
  function void set_relay(input bit on, input logic [CODE_W-1:0] code,
                          input logic [NOW_W-1:0] stamp);
    int slot;
    if (on == relay) return;
    relay = on;
    if (on) begin
      spray_start   = stamp;
      spray_running = 1'b1;
    end else begin
      spray_end     = stamp;
      spray_running = 1'b0;
      has_sprayed   = 1'b1;
    end
    slot = (step_changes < 2) ? step_changes : 1;
    step_code[slot]  = code;
    step_relay[slot] = on;
    if (step_changes < 2) step_changes++;
  endfunction

  always @(posedge clk) begin : track
    int               total;
    int               fresh_n;
    int               avg;
    int               thr;
    int               start;
    int               span;
    int               cur;
    int               t;
    int               k;
    bit               sched;
    logic [MODE_W-1:0] mode;
    logic [NOW_W-1:0] elapsed;
    relay_result_t    want;
    relay_result_t    got;

    if (rst) begin
      cfg_regs[REG_THRESHOLD]   = 16'd480;
      cfg_regs[REG_HYSTERESIS]  = 16'd16;
      cfg_regs[REG_MAX_ON]      = 16'd120;
      cfg_regs[REG_COOLDOWN]    = 16'd60;
      cfg_regs[REG_MODE]        = 16'(MODE_AUTO);
      cfg_regs[REG_SCHED_EN]    = 16'd0;
      cfg_regs[REG_SCHED_START] = 16'd720;
      cfg_regs[REG_SCHED_LEN]   = 16'd10;
      for (k = 0; k < NUM_SENSORS; k++) begin
        reading[k]       = BOOT_READING;
        reading_fresh[k] = 1'b1;
      end
      held_average    = BOOT_READING;
      relay           = 1'b0;
      spray_running   = 1'b0;
      has_sprayed     = 1'b0;
      window_was_open = 1'b0;
      spray_start     = '0;
      spray_end       = '0;
      relay_events_due.delete();
    end else begin
      // Track register writes
      if (cfg_write) cfg_regs[cfg_index] = cfg_data & reg_mask(cfg_index);

      // Compare a delivered result with the oldest expectation
      if (out_valid && !out_stall) begin
        got = {relay_on, event_code, average, schedule_active, last};
        if (relay_events_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with none expected: relay %b code %0d avg %0d sched %b last %b",
                     $time, got.relay, got.code, $signed(got.avg), got.sched, got.last);
        end else begin
          want = relay_events_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"%0t: result mismatch: expected relay %b code %0d avg %0d sched %b ",
                        "last %b, got relay %b code %0d avg %0d sched %b last %b"},
                       $time, want.relay, want.code, $signed(want.avg), want.sched,
                       want.last, got.relay, got.code, $signed(got.avg), got.sched,
                       got.last);
          end
        end
      end

      // Advance the thermostat on an accepted transaction
      if (in_valid && !in_stall) begin
        if (cmd != CONTROL) begin
          t = temperature;
          if (sensor_index < NUM_SENSORS) begin
            if (sensor_present && t >= LOW_READING && t <= HIGH_READING) begin
              reading[sensor_index]       = t;
              reading_fresh[sensor_index] = 1'b1;
            end else begin
              reading_fresh[sensor_index] = 1'b0;
            end
          end
        end else begin
          // Average the fresh sensors, keep the old average if none
          total   = 0;
          fresh_n = 0;
          for (k = 0; k < NUM_SENSORS; k++) begin
            if (reading_fresh[k]) begin
              total += reading[k];
              fresh_n++;
            end
          end
          if (fresh_n > 0) held_average = total / fresh_n;
          avg = held_average;
          thr = $signed(cfg_regs[REG_THRESHOLD][AVG_W-1:0]);

          // Daily window, possibly wrapping at midnight
          start = cfg_regs[REG_SCHED_START][MIN_W-1:0];
          span  = cfg_regs[REG_SCHED_LEN][MIN_W-1:0];
          cur   = minute_of_day;
          if (!cfg_regs[REG_SCHED_EN][0] || !clock_valid || span == 0)
            sched = 1'b0;
          else if (start + span <= DAY_MINUTES)
            sched = (cur >= start) && (cur < start + span);
          else
            sched = (cur >= start) || (cur < (start + span) % DAY_MINUTES);

          step_changes = 0;
          mode = cfg_regs[REG_MODE][MODE_W-1:0];
          if (mode == MODE_AUTO) begin
            if (!relay && avg >= thr) begin
              elapsed = now_ms - spray_end;
              if (!has_sprayed || elapsed / MS_PER_SECOND >= cfg_regs[REG_COOLDOWN])
                set_relay(1'b1, EV_AUTO_ON, now_ms);
            end else if (relay &&
                         avg <= thr - int'(cfg_regs[REG_HYSTERESIS][HYST_W-1:0])) begin
              set_relay(1'b0, EV_AUTO_OFF, now_ms);
            end
            elapsed = now_ms - spray_start;
            if (relay && spray_running && elapsed / MS_PER_SECOND >= cfg_regs[REG_MAX_ON])
              set_relay(1'b0, EV_PROTECT_OFF, now_ms);
            if (sched && !relay)
              set_relay(1'b1, EV_SCHED_ON, now_ms);
            else if (!sched && window_was_open && relay && avg < thr)
              set_relay(1'b0, EV_SCHED_OFF, now_ms);
            window_was_open = sched;
          end else if (mode == MODE_MANUAL_ON) begin
            set_relay(1'b1, EV_MANUAL_ON, now_ms);
          end else begin
            set_relay(1'b0, EV_MANUAL_OFF, now_ms);
          end

          // No change still reports the relay once
          if (step_changes == 0) begin
            step_code[0]  = EV_NONE;
            step_relay[0] = relay;
            step_changes  = 1;
          end
          for (k = 0; k < step_changes; k++) begin
            want.relay = step_relay[k];
            want.code  = step_code[k];
            want.avg   = AVG_W'(avg);
            want.sched = sched;
            want.last  = (k == step_changes - 1);
            relay_events_due.push_back(want);
          end
        end
      end
    end

    mismatches  <= fail_count;
    outstanding <= relay_events_due.size();
  end

endmodule

### test/hysteresis_relay_controller_tb.sv
// ----------------------------------------------------------------------------
// Hysteresis relay controller testbench
// Drives sensor and control transactions through the relay controller under
// a series of register settings: a directed pass over the field extremes and
// the corner cases of the thermostat, then random sensor rounds with random
// idling on both channels. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module hysteresis_relay_controller_tb
  import hrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic SAMPLE  = 1'b0;
  localparam logic CONTROL = 1'b1;
  localparam logic [MODE_W-1:0] MODE_MANUAL_OFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNDEFINED  = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 212;
  localparam int NUM_PHASES    = 9;

  typedef struct packed {
    int thr;
    int hyst;
    int max_on;
    int cooldown;
    int mode;
    int sched_en;
    int start;
    int span;
  } cfg_set_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFGIDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     cmd = 1'b0;
  logic [SIDX_W-1:0]        sensor_index = '0;
  logic signed [TEMP_W-1:0] temperature = '0;
  logic                     sensor_present = 1'b0;
  logic [NOW_W-1:0]         now_ms = '0;
  logic [MIN_W-1:0]         minute_of_day = '0;
  logic                     clock_valid = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     relay_on;
  logic [CODE_W-1:0]        event_code;
  logic signed [AVG_W-1:0]  average;
  logic                     schedule_active;
  logic                     last;
  int                       mismatches;
  int                       outstanding;

  int               gap_pct = 11;
  int               stall_pct = 49;
  bit               hold_request = 1'b0;
  int               hold_count = 0;
  int               cycle_count = 0;
  int               item_count = 0;
  int               minute_now = 0;
  logic [NOW_W-1:0] clock_ms = '0;
  cfg_set_t         live_cfg;

  hysteresis_relay_controller dut (.*);

  hysteresis_relay_controller_checker checker_i (.*);

  always #5 clk = ~clk;

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_count <= 0;
    end else if (hold_count > 0) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count - 1;
    end else if (hold_request) begin
      out_stall  <= 1'b1;
      hold_count <= LONG_HOLD;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hysteresis_relay_controller_tb: FAIL");
      $finish;
    end
  end

  // Offer one transaction, idling at random first; returns once input is no longer stalled
  task automatic send_item(input logic c, input int idx, input int t, input logic present,
                           input logic [NOW_W-1:0] stamp, input int minute, input logic cv);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= c;
    sensor_index   <= SIDX_W'(idx);
    temperature    <= TEMP_W'(t);
    sensor_present <= present;
    now_ms         <= stamp;
    minute_of_day  <= MIN_W'(minute);
    clock_valid    <= cv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CONTROL || idx < NUM_SENSORS_DEF) item_count++;
  endtask

  // Write all eight registers back to back
  task automatic write_config(input cfg_set_t s);
    logic [CFG_W-1:0] value [8];
    int i;
    value[REG_THRESHOLD]   = CFG_W'(s.thr);
    value[REG_HYSTERESIS]  = CFG_W'(s.hyst);
    value[REG_MAX_ON]      = CFG_W'(s.max_on);
    value[REG_COOLDOWN]    = CFG_W'(s.cooldown);
    value[REG_MODE]        = CFG_W'(s.mode);
    value[REG_SCHED_EN]    = CFG_W'(s.sched_en);
    value[REG_SCHED_START] = CFG_W'(s.start);
    value[REG_SCHED_LEN]   = CFG_W'(s.span);
    for (i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFGIDX_W'(i);
      cfg_data  <= value[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    live_cfg = s;
  endtask

  // Drop valid and wait until every result is in and the block has settled
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One round: a few sensor readings and a control step, or a noise transaction
  task automatic random_round();
    int   samples;
    int   i;
    int   r;
    int   t;
    int   minute;
    logic present;
    if ($urandom_range(99) < 15) begin
      send_item(1'($urandom_range(1)), $urandom_range(7), int'($urandom_range(8191)) - 4096,
                1'($urandom_range(1)), $urandom(), $urandom_range(2047),
                1'($urandom_range(1)));
    end else begin
      samples = $urandom_range(6);
      for (i = 0; i < samples; i++) begin
        r = $urandom_range(99);
        present = 1'b1;
        if (r < 70)
          t = live_cfg.thr - live_cfg.hyst - 24 + $urandom_range(live_cfg.hyst + 48);
        else if (r < 88)
          t = int'(TEMP_LOW) + $urandom_range(int'(TEMP_HIGH) - int'(TEMP_LOW));
        else if (r < 94)
          t = int'($urandom_range(8191)) - 4096;
        else begin
          t = int'($urandom_range(8191)) - 4096;
          present = 1'b0;
        end
        send_item(SAMPLE, $urandom_range(NUM_SENSORS_DEF - 1), t, present, $urandom(),
                  $urandom_range(2047), 1'($urandom_range(1)));
      end
      // Advance wall time and minute of day
      if ($urandom_range(99) < 90) clock_ms += $urandom_range(8000);
      else clock_ms += $urandom_range(400000);
      minute_now = (minute_now + $urandom_range(60)) % int'(MIN_PER_DAY);
      minute = ($urandom_range(99) < 5) ? $urandom_range(2047) : minute_now;
      send_item(CONTROL, $urandom_range(7), int'($urandom_range(8191)) - 4096,
                1'($urandom_range(1)), clock_ms, minute, ($urandom_range(99) < 95));
    end
  endtask

  initial begin
    cfg_set_t plan [NUM_PHASES];
    cfg_set_t tweak;
    int       p;
    int       quota;
    bit       held;
    bit       paused;

    plan[0] = '{480, 16, 30, 10, MODE_AUTO, 1, 1380, 180};
    plan[1] = '{2000, 1024, 65535, 65535, MODE_AUTO, 1, 1439, 1440};
    plan[2] = '{-880, 0, 0, 0, MODE_AUTO, 0, 0, 0};
    plan[3] = '{480, 16, 40, 20, MODE_MANUAL_ON, 1, 600, 100};
    plan[4] = '{320, 48, 20, 5, MODE_MANUAL_OFF, 1, 0, 1440};
    plan[5] = '{320, 48, 20, 5, MODE_AUTO, 1, 2047, 2047};
    plan[6] = '{400, 32, 60, 0, MODE_AUTO, 1, 0, 0};
    plan[7] = '{int'(TEMP_LOW) + $urandom_range(2880), $urandom_range(1024),
                $urandom_range(90), $urandom_range(90), $urandom_range(3),
                $urandom_range(1), $urandom_range(1439), $urandom_range(1440)};
    plan[8] = '{600, 100, 10, 30, MODE_AUTO, 1, 100, 300};
    held   = 1'b0;
    paused = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, field extremes, rejected and ignored readings
    write_config('{480, 16, 120, 60, MODE_AUTO, 0, 720, 10});
    send_item(CONTROL, 0, 0, 1'b0, 32'd0, 0, 1'b0);
    send_item(SAMPLE, 0, 2000, 1'b1, 32'd0, 0, 1'b0);
    // first turn-on ignores cooldown
    send_item(CONTROL, 7, -4096, 1'b1, 32'd1000, 720, 1'b1);
    send_item(SAMPLE, 1, -4096, 1'b1, 32'hFFFF_FFFF, 2047, 1'b1);
    send_item(SAMPLE, 2, 4095, 1'b1, 32'd0, 0, 1'b0);
    send_item(SAMPLE, 3, -881, 1'b1, 32'd0, 0, 1'b0);
    send_item(SAMPLE, 4, 2001, 1'b1, 32'd0, 0, 1'b0);
    send_item(SAMPLE, 5, 0, 1'b0, 32'd0, 0, 1'b0);
    send_item(SAMPLE, 6, 100, 1'b1, 32'd0, 0, 1'b0);
    send_item(SAMPLE, 7, 100, 1'b1, 32'd0, 0, 1'b0);
    // maximum on time reached
    send_item(CONTROL, 0, 0, 1'b0, 32'd121000, 0, 1'b0);
    send_item(SAMPLE, 0, -880, 1'b1, 32'd0, 0, 1'b0);
    send_item(CONTROL, 0, 0, 1'b0, 32'd121500, 0, 1'b0);
    // no fresh sensor: keep the last average
    send_item(SAMPLE, 0, 1000, 1'b0, 32'd0, 0, 1'b0);
    send_item(CONTROL, 0, 0, 1'b0, 32'hFFFF_FFFF, 2047, 1'b1);
    // cooldown blocks, then allows, a turn-on
    send_item(SAMPLE, 1, 2000, 1'b1, 32'd0, 0, 1'b0);
    send_item(CONTROL, 0, 0, 1'b0, 32'd150000, 0, 1'b0);
    send_item(CONTROL, 0, 0, 1'b0, 32'd181000, 0, 1'b0);

    // Directed: zero on time and a full-day window give up to three changes
    wait_for_idle();
    tweak = '{-880, 0, 0, 0, MODE_AUTO, 1, 0, 1440};
    write_config(tweak);
    send_item(CONTROL, 0, 0, 1'b0, 32'd200000, 100, 1'b1);
    send_item(CONTROL, 0, 0, 1'b0, 32'd200000, 2047, 1'b1);
    send_item(CONTROL, 0, 0, 1'b0, 32'd200000, 5, 1'b1);

    // Directed: manual modes, the undefined one acting as manual off
    wait_for_idle();
    tweak.mode = MODE_UNDEFINED;
    write_config(tweak);
    send_item(CONTROL, 0, 0, 1'b0, 32'd201000, 5, 1'b1);
    wait_for_idle();
    tweak.mode = MODE_MANUAL_ON;
    write_config(tweak);
    send_item(CONTROL, 0, 0, 1'b0, 32'd202000, 5, 1'b1);
    wait_for_idle();
    tweak.mode = MODE_MANUAL_OFF;
    write_config(tweak);
    send_item(CONTROL, 0, 0, 1'b0, 32'd203000, 5, 1'b1);

    // Random rounds under each setting
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_for_idle();
      gap_pct = (p < 3) ? 11 : (p < 6) ? 49 : 0;
      stall_pct <= (p < 3) ? 49 : (p < 6) ? 11 : 0;
      write_config(plan[p]);
      if (p == 0) clock_ms = 32'hFFFF_0000;
      quota = item_count + PHASE_ITEMS;
      while (item_count < quota) begin
        if (p == 1 && !held && item_count >= quota - PHASE_ITEMS / 2) begin
          // hold the output off while items keep coming
          hold_request <= 1'b1;
          held = 1'b1;
          random_round();
          hold_request <= 1'b0;
        end else if (p == 4 && !paused && item_count >= quota - PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_for_idle();
        end else begin
          random_round();
        end
      end
    end

    wait_for_idle();
    if (mismatches == 0 && outstanding == 0)
      $display("hysteresis_relay_controller_tb: PASS");
    else
      $display("hysteresis_relay_controller_tb: FAIL");
    $finish;
  end

endmodule
